// ===== src/ffca_pkg.sv =====
// Shared constants, codes and types of the first-fit chunk allocator.
package ffca_pkg;

  localparam int MAX_CHUNKS  = 1024;
  localparam int CHUNK_BYTES = 4096;  // power of two
  localparam int OWNER_BITS  = 8;

  localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int IDX_W       = $clog2(MAX_CHUNKS);
  localparam int LIM_W       = $clog2(MAX_CHUNKS + 1);
  localparam int CNT_W       = $clog2(MAX_CHUNKS + 2);

  localparam int OP_W        = 2;
  localparam int AMOUNT_W    = 32;
  localparam int OWNER_W     = 8;
  localparam int ADDR_W      = 32;
  localparam int CHUNK_IDX_W = 10;
  localparam int TOTAL_W     = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TOTAL_W-1:0]    TOTAL_RESET = TOTAL_W'(1024);
  localparam logic [OWNER_BITS-1:0] TAG_FREE    = '0;
  localparam logic [OWNER_BITS-1:0] TAG_CONT    = '1;

  typedef enum logic [OP_W-1:0] {
    OP_COUNT = 2'd0,
    OP_BYTES = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_BASE   = 1'b0,
    CFG_TOTAL_CHUNKS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                  alloc;
    logic                  free;
    logic [CNT_W-1:0]      count;  // saturated at MAX_CHUNKS + 1
    logic [OWNER_BITS-1:0] owner;
    logic [IDX_W-1:0]      idx;
    logic                  oob;
  } cmd_t;

  typedef struct packed {
    logic             status;
    logic             has_addr;
    logic [IDX_W-1:0] idx;
  } res_t;

endpackage

// ===== src/ffca_if.sv =====
// Request and response channel interfaces of the chunk allocator.
interface ffca_req_if import ffca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [AMOUNT_W-1:0] amount;
  logic [OWNER_W-1:0]  owner;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, operation, amount, owner, address, input ready);
  modport sink   (input valid, operation, amount, owner, address, output ready);
endinterface

interface ffca_rsp_if import ffca_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic [ADDR_W-1:0]      chunk_address;
  logic [CHUNK_IDX_W-1:0] chunk_index;

  modport source (output valid, status, chunk_address, chunk_index, input ready);
  modport sink   (input valid, status, chunk_address, chunk_index, output ready);
endinterface

// ===== src/ffca_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== src/ffca_decode.sv =====
// Request decode: chunk count rounding and saturation, free index and range check.
module ffca_decode import ffca_pkg::*; (
  input  logic [OP_W-1:0]     operation_i,
  input  logic [AMOUNT_W-1:0] amount_i,
  input  logic [OWNER_W-1:0]  owner_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [ADDR_W-1:0]   chunk_base_i,
  input  logic [LIM_W-1:0]    lim_i,
  output cmd_t                cmd_o
);

  op_e               op;
  logic [AMOUNT_W-1:0] raw;
  logic [AMOUNT_W-1:0] cnt;
  logic [ADDR_W-1:0]   diff;
  logic [ADDR_W-1:0]   quot;

  always_comb begin
    op = op_e'(operation_i);
    case (op)
      OP_BYTES: raw = (amount_i >> CHUNK_SHIFT) +
                      AMOUNT_W'(|amount_i[CHUNK_SHIFT-1:0]);
      default:  raw = amount_i;
    endcase
    cnt = (raw == '0) ? AMOUNT_W'(1) : raw;

    diff = address_i - chunk_base_i;
    quot = diff >> CHUNK_SHIFT;

    cmd_o.alloc = op inside {OP_COUNT, OP_BYTES};
    cmd_o.free  = (op == OP_FREE);
    cmd_o.count = (cnt > AMOUNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS + 1)
                                                : cnt[CNT_W-1:0];
    cmd_o.owner = OWNER_BITS'(owner_i);
    cmd_o.idx   = quot[IDX_W-1:0];
    cmd_o.oob   = quot >= ADDR_W'(lim_i);
  end

endmodule

// ===== src/ffca_seq.sv =====
// Owner table sequencer: clearing pass, first-fit scan, tagging, free and first-free upkeep.
module ffca_seq import ffca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LIM_W-1:0] lim_i,
  input  logic             in_fire_i,
  input  cmd_t             cmd_i,
  output logic             in_ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_WRITE   = 7'b0001000,
    S_REFRESH = 7'b0010000,
    S_FREE    = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [LIM_W-1:0]      ptr_q, ptr_d;
  logic [LIM_W-1:0]      end_q, end_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]      run_start_q, run_start_d;
  logic [CNT_W-1:0]      run_len_q, run_len_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic [IDX_W-1:0]      ff_q, ff_d;
  logic                  ffv_q, ffv_d;
  res_t                  res_q, res_d;

  logic                  issue;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [OWNER_BITS-1:0] wr_data;
  logic [OWNER_BITS-1:0] rdata;
  logic                  ptr_lt;
  logic                  rd_free;
  logic [CNT_W-1:0]      new_len;
  logic [IDX_W-1:0]      start_now;
  logic                  found;

  ffca_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (MAX_CHUNKS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (issue),
    .rd_addr_i (ptr_q[IDX_W-1:0]),
    .rd_data_o (rdata)
  );

  assign ptr_lt    = ptr_q < lim_i;
  assign rd_free   = rd_vld_q && (rdata == TAG_FREE);
  assign new_len   = run_len_q + CNT_W'(1);
  assign start_now = (run_len_q == '0) ? rd_idx_q : run_start_q;
  assign found     = rd_free && (new_len == count_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    count_d     = count_q;
    owner_d     = owner_q;
    ff_d        = ff_q;
    ffv_d       = ffv_q;
    res_d       = res_q;
    issue       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = ptr_q[IDX_W-1:0];
    wr_data     = TAG_FREE;

    case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        ptr_d = ptr_q + LIM_W'(1);
        if (ptr_q == LIM_W'(MAX_CHUNKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire_i) begin
          res_d = '0;
          if (cmd_i.alloc) begin
            count_d   = cmd_i.count;
            owner_d   = cmd_i.owner;
            run_len_d = '0;
            ptr_d     = LIM_W'(ff_q);
            if (ffv_q) begin
              state_d = S_SCAN;
            end else begin
              res_d.status = 1'b1;
              state_d      = S_RESP;
            end
          end else if (cmd_i.free && !cmd_i.oob) begin
            wr_en     = 1'b1;
            wr_addr   = cmd_i.idx;
            ptr_d     = LIM_W'(cmd_i.idx) + LIM_W'(1);
            res_d.idx = cmd_i.idx;
            if (!ffv_q || (cmd_i.idx < ff_q)) begin
              ff_d  = cmd_i.idx;
              ffv_d = 1'b1;
            end
            state_d = S_FREE;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_q) begin
          run_len_d   = rd_free ? new_len : '0;
          run_start_d = start_now;
        end
        if (found) begin
          ptr_d   = LIM_W'(start_now);
          end_d   = LIM_W'(rd_idx_q) + LIM_W'(1);
          state_d = S_WRITE;
        end else if (!ptr_lt) begin
          res_d.status = 1'b1;
          state_d      = S_RESP;
        end else begin
          issue = 1'b1;
          ptr_d = ptr_q + LIM_W'(1);
        end
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_data = (ptr_q[IDX_W-1:0] == run_start_q) ? owner_q : TAG_CONT;
        ptr_d   = ptr_q + LIM_W'(1);
        res_d   = '{status: 1'b0, has_addr: 1'b1, idx: run_start_q};
        if (ptr_d == end_q) begin
          state_d = (run_start_q == ff_q) ? S_REFRESH : S_RESP;
        end
      end
      S_REFRESH: begin
        if (rd_free) begin
          ff_d    = rd_idx_q;
          ffv_d   = 1'b1;
          state_d = S_RESP;
        end else if (!ptr_lt) begin
          ffv_d   = 1'b0;
          state_d = S_RESP;
        end else begin
          issue = 1'b1;
          ptr_d = ptr_q + LIM_W'(1);
        end
      end
      S_FREE: begin
        if (rd_vld_q && (rdata == TAG_CONT)) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_q;
        end
        if ((rd_vld_q && (rdata != TAG_CONT)) || !ptr_lt) begin
          state_d = S_RESP;
        end else begin
          issue = 1'b1;
          ptr_d = ptr_q + LIM_W'(1);
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rd_vld_d = issue;
    rd_idx_d = ptr_q[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
      ff_q     <= '0;
      ffv_q    <= 1'b1;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_vld_d;
      ff_q     <= ff_d;
      ffv_q    <= ffv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q       <= end_d;
    rd_idx_q    <= rd_idx_d;
    run_start_q <= run_start_d;
    run_len_q   <= run_len_d;
    count_q     <= count_d;
    owner_q     <= owner_d;
    res_q       <= res_d;
  end

  a_run_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (run_len_q < count_q))
    else $error("free run reached request size without allocating");

  a_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (ptr_q < end_q))
    else $error("tag write past end of run");

  a_read_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ((state_q == S_SCAN) || (state_q == S_REFRESH) || (state_q == S_FREE)))
    else $error("table read data returned outside a streaming state");

  a_ready_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> in_ready_o)
    else $error("not ready after response handoff");

endmodule

// ===== src/first_fit_chunk_allocator.sv =====
// Top level of the first-fit chunk allocator: config registers, decode, sequencer, response register.
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        operation, amount, owner, address
//   rsp_o    out  valid/ready        status, chunk_address, chunk_index
//   cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// One request at a time. The owner table has one read port, one entry per cycle:
//   allocate: first-fit scan, tagging of the run, then a rescan if it took the first free chunk.
//   free: clear the tag, then the continuation chunks that follow.
// After reset a clearing pass over all MAX_CHUNKS (1024) entries runs with req_i.ready low.
// A response held by a stalled rsp_o does not block acceptance of the next request.
module first_fit_chunk_allocator import ffca_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ffca_req_if.sink              req_i,
  ffca_rsp_if.source            rsp_o
);

  logic [ADDR_W-1:0]  base_q;
  logic [TOTAL_W-1:0] total_q;
  logic [LIM_W-1:0]   lim;
  cmd_t               cmd;
  res_t               res;
  logic               in_ready;
  logic               in_fire;
  logic               res_valid;
  logic               res_ready;
  logic               out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      total_q <= TOTAL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHUNK_BASE:   base_q  <= cfg_data_i;
        CFG_TOTAL_CHUNKS: total_q <= cfg_data_i[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign lim = (32'(total_q) > 32'(MAX_CHUNKS)) ? LIM_W'(MAX_CHUNKS) : LIM_W'(total_q);

  ffca_decode u_decode (
    .operation_i  (req_i.operation),
    .amount_i     (req_i.amount),
    .owner_i      (req_i.owner),
    .address_i    (req_i.address),
    .chunk_base_i (base_q),
    .lim_i        (lim),
    .cmd_o        (cmd)
  );

  assign req_i.ready = in_ready;
  assign in_fire     = req_i.valid && in_ready;

  ffca_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .in_fire_i   (in_fire),
    .cmd_i       (cmd),
    .in_ready_o  (in_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_vld_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      rsp_o.status        <= res.status;
      rsp_o.chunk_index   <= CHUNK_IDX_W'(res.idx);
      rsp_o.chunk_address <= res.has_addr ? base_q + (ADDR_W'(res.idx) << CHUNK_SHIFT) : '0;
    end
  end

  assign rsp_o.valid = out_vld_q;

endmodule
